[hdl/tws_pkg.sv]
// Shared types and constants for the three-wire serial master.
package tws_pkg;

  // Delay unit length after reset, in ticks.
  localparam logic [7:0] HALF_PERIOD_RESET = 8'd1;

  // Default depth of the word queue between the front and back parts.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Transaction kinds carried in the opcode field of an input word.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // One input word: one tick of the timebase with its request and line sample.
  typedef struct packed {
    logic       start_req;
    logic       opcode;
    logic [7:0] command_byte;
    logic [7:0] write_data;
    logic       io_in;
  } in_word_t;

  // One result word: line levels and status after the tick.
  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_result;
  } out_word_t;

endpackage

[hdl/tws_front.sv]
// Front part: accepts input words and holds them in a short queue for the back part.
module tws_front import tws_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  output logic     q_valid,
  output in_word_t q_word,
  input  logic     q_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  in_word_t         store_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;

  assign in_stall = (count_r == CNT_FULL);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_word   = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= in_word;
    end
  end

endmodule

[hdl/tws_back.sv]
// Back part: the link sequencer, stepping once per queued tick, with its result register.
module tws_back import tws_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic      q_valid,
  input  in_word_t  q_word,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_CE_GAP    = 4'd1;
  localparam logic [3:0] PH_TX_LOW    = 4'd2;
  localparam logic [3:0] PH_TX_HIGH   = 4'd3;
  localparam logic [3:0] PH_RD_WAIT   = 4'd4;
  localparam logic [3:0] PH_RX_LOW    = 4'd5;
  localparam logic [3:0] PH_RX_HIGH   = 4'd6;
  localparam logic [3:0] PH_END_W     = 4'd7;
  localparam logic [3:0] PH_TAIL_REL  = 4'd8;
  localparam logic [3:0] PH_TAIL_LOW  = 4'd9;
  localparam logic [3:0] PH_TAIL_HIGH = 4'd10;

  localparam logic [3:0] LAST_READ_BIT  = 4'd7;
  localparam logic [3:0] LAST_WRITE_BIT = 4'd15;

  logic [7:0]  half_period_r;
  logic [3:0]  phase_r, phase_nxt;
  logic [3:0]  bit_index_r, bit_index_nxt;
  logic [8:0]  delay_r, delay_nxt;
  logic [15:0] out_shift_r, out_shift_nxt;
  logic [7:0]  in_shift_r, in_shift_nxt;
  logic        is_read_r, is_read_nxt;
  out_word_t   out_word_r, out_word_nxt;
  logic        out_valid_r;

  logic        step;
  logic        done;
  logic [7:0]  unit;
  logic [8:0]  one_unit;
  logic [8:0]  two_units;
  logic [8:0]  delay_dec;

  assign step      = q_valid && (!out_valid_r || !out_stall);
  assign q_pop     = step;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // A zero half period behaves as one tick.
  assign unit      = (half_period_r == 8'd0) ? 8'd1 : half_period_r;
  assign one_unit  = {1'b0, unit};
  assign two_units = {unit, 1'b0};
  assign delay_dec = (delay_r != 9'd0) ? delay_r - 9'd1 : 9'd0;

  always_comb begin
    phase_nxt     = phase_r;
    bit_index_nxt = bit_index_r;
    delay_nxt     = delay_r;
    out_shift_nxt = out_shift_r;
    in_shift_nxt  = in_shift_r;
    is_read_nxt   = is_read_r;
    done          = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (q_word.start_req) begin
        is_read_nxt   = (q_word.opcode == OP_READ);
        out_shift_nxt = {q_word.write_data, q_word.command_byte};
        bit_index_nxt = 4'd0;
        phase_nxt     = PH_CE_GAP;
        delay_nxt     = one_unit;
      end
    end else if (delay_dec != 9'd0) begin
      delay_nxt = delay_dec;
    end else begin
      unique case (phase_r)
        PH_CE_GAP: begin
          bit_index_nxt = 4'd0;
          phase_nxt     = PH_TX_LOW;
          delay_nxt     = one_unit;
        end
        PH_TX_LOW: begin
          phase_nxt = PH_TX_HIGH;
          delay_nxt = one_unit;
        end
        PH_TX_HIGH: begin
          if (bit_index_r >= (is_read_r ? LAST_READ_BIT : LAST_WRITE_BIT)) begin
            phase_nxt = is_read_r ? PH_RD_WAIT : PH_END_W;
            delay_nxt = is_read_r ? two_units : one_unit;
          end else begin
            bit_index_nxt = bit_index_r + 4'd1;
            out_shift_nxt = {1'b0, out_shift_r[15:1]};
            phase_nxt     = PH_TX_LOW;
            delay_nxt     = one_unit;
          end
        end
        PH_RD_WAIT: begin
          bit_index_nxt = 4'd0;
          phase_nxt     = PH_RX_LOW;
          delay_nxt     = one_unit;
        end
        PH_RX_LOW: begin
          in_shift_nxt = {q_word.io_in, in_shift_r[7:1]};
          phase_nxt    = PH_RX_HIGH;
          delay_nxt    = one_unit;
        end
        PH_RX_HIGH: begin
          if (bit_index_r >= LAST_READ_BIT) begin
            phase_nxt = PH_TAIL_REL;
          end else begin
            bit_index_nxt = bit_index_r + 4'd1;
            phase_nxt     = PH_RX_LOW;
          end
          delay_nxt = one_unit;
        end
        PH_TAIL_REL: begin
          phase_nxt = PH_TAIL_LOW;
          delay_nxt = one_unit;
        end
        PH_TAIL_LOW: begin
          phase_nxt = PH_TAIL_HIGH;
          delay_nxt = one_unit;
        end
        default: begin
          // End of a write, end of the read tail, or an unused code.
          phase_nxt = PH_IDLE;
          delay_nxt = 9'd0;
          done      = 1'b1;
        end
      endcase
    end
  end

  // Line levels follow the phase the step ends in.
  always_comb begin
    out_word_nxt              = '0;
    out_word_nxt.busy_res     = (phase_nxt != PH_IDLE);
    out_word_nxt.done_res     = done;
    out_word_nxt.read_result  = in_shift_nxt;
    unique case (phase_nxt)
      PH_CE_GAP, PH_TX_LOW: begin
        out_word_nxt.chip_enable = 1'b1;
        out_word_nxt.io_drive    = 1'b1;
        out_word_nxt.io_out      = out_shift_nxt[0];
      end
      PH_TX_HIGH: begin
        out_word_nxt.chip_enable  = 1'b1;
        out_word_nxt.serial_clock = 1'b1;
        out_word_nxt.io_drive     = 1'b1;
        out_word_nxt.io_out       = out_shift_nxt[0];
      end
      PH_RD_WAIT, PH_RX_HIGH: begin
        out_word_nxt.chip_enable  = 1'b1;
        out_word_nxt.serial_clock = 1'b1;
      end
      PH_RX_LOW: begin
        out_word_nxt.chip_enable = 1'b1;
      end
      PH_END_W: begin
        out_word_nxt.io_drive = 1'b1;
        out_word_nxt.io_out   = out_shift_nxt[0];
      end
      PH_TAIL_LOW: begin
        out_word_nxt.io_drive = 1'b1;
      end
      PH_TAIL_HIGH: begin
        out_word_nxt.io_drive = 1'b1;
        out_word_nxt.io_out   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RESET;
      phase_r       <= PH_IDLE;
      bit_index_r   <= 4'd0;
      delay_r       <= 9'd0;
      out_shift_r   <= 16'd0;
      in_shift_r    <= 8'd0;
      is_read_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        half_period_r <= cfg_wdata;
      end
      if (step) begin
        phase_r     <= phase_nxt;
        bit_index_r <= bit_index_nxt;
        delay_r     <= delay_nxt;
        out_shift_r <= out_shift_nxt;
        in_shift_r  <= in_shift_nxt;
        is_read_r   <= is_read_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

[hdl/three_wire_serial_master_top.sv]
// Top level of the three-wire serial master: front queue and back sequencer.
//
//   Channel  Direction  Handshake                    Word
//   in_      input      in_valid / in_stall          in_word_t, one timebase tick
//   out_     output     out_valid / out_stall        out_word_t, line levels per tick
//   cfg_     input      cfg_we, no back-pressure     half period in ticks
//
// The block takes one input word every clock cycle while in_stall is low, and returns
// one result word for each, in order. A word passes the queue (two entries by default)
// and the result register: the sequencer steps it once it is at the queue head, and
// the result register holds its result until taken; the sequencer takes one word per
// cycle, limited only by the result register being free.
// Reset is synchronous and active low; it empties the queue, idles the sequencer and
// sets the half period to one tick. A stall on the result side holds the result
// register; the queue keeps taking words until it is full, then raises in_stall.
module three_wire_serial_master_top import tws_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_word,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  // Queue head as seen by the sequencer.
  logic     q_valid;
  in_word_t q_word;
  logic     q_pop;

  // The front buffers ticks so that a stalled result side does not stop acceptance
  // at once.
  tws_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  // The back steps the link sequencer once per tick and registers the line levels.
  tws_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
